### design/slwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_pkg: shared types and constants for the LIKE wildcard matcher
// Holds the request codes, the pattern cell kinds, the special pattern
// characters and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package slwm_pkg;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  // Compiled pattern cell kinds
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ANY     = 2'd1,
    KIND_STAR    = 2'd2
  } kind_e;

  // Pattern metacharacters
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

  // Finish reduction groups hit bits in slices of this size
  localparam int unsigned GROUP_SIZE = 8;

  // Command broadcast to every cell
  typedef struct packed {
    logic       clear;  // start: drop pattern, reset active set
    logic       text;   // text character: advance active set
    logic       add;    // append a cell at the tail
    kind_e      kind;   // kind of the appended cell
    logic [7:0] ch;     // pattern or text character
  } cell_cmd_t;

  // Data handed from one cell to its right neighbor
  typedef struct packed {
    logic valid;     // cell holds a pattern entry
    logic star_act;  // active star cell: right position may match empty
    logic adv;       // cell consumes the text character, activate right
  } link_t;

endpackage

### design/slwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_cell: one position of the matcher chain
// Holds one compiled pattern cell and the active bit of the position in
// front of it. Closes over a star on its left and passes the advance of
// its own cell to the right neighbor on every text character.
// ----------------------------------------------------------------------------
module slwm_cell import slwm_pkg::*; #(
  parameter bit ActInit = 1'b0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  link_t     left_i,
  output link_t     right_o,
  output logic      tail_o,
  output logic      hit_o
);

  logic       valid_q, valid_d;
  logic       act_q, act_d;
  kind_e      kind_q;
  logic [7:0] char_q;

  logic closed;
  logic is_star;
  logic char_hit;

  // Locate the tail and close the active bit over a star on the left
  assign tail_o   = left_i.valid & ~valid_q;
  assign closed   = act_q | left_i.star_act;
  assign is_star  = (kind_q == KIND_STAR);
  assign char_hit = (kind_q == KIND_ANY) ||
                    ((kind_q == KIND_LITERAL) && (char_q == cmd_i.ch));

  // Hand state to the right neighbor
  assign right_o.valid    = valid_q;
  assign right_o.star_act = act_q & valid_q & is_star;
  assign right_o.adv      = closed & valid_q & ~is_star & char_hit;

  // End of pattern reached with this position active
  assign hit_o = closed & tail_o;

  // Next valid and active bits
  always_comb begin
    valid_d = valid_q;
    act_d   = act_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
      act_d   = ActInit;
    end else if (cmd_i.text) begin
      act_d = (closed & valid_q & is_star) | left_i.adv;
    end else if (cmd_i.add && tail_o) begin
      valid_d = 1'b1;
    end
  end

  // Hold control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= ActInit;
    end else begin
      valid_q <= valid_d;
      act_q   <= act_d;
    end
  end

  // Store the pattern entry when this cell is the tail
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && tail_o && !cmd_i.clear) begin
      kind_q <= cmd_i.kind;
      char_q <= cmd_i.ch;
    end
  end

endmodule

### design/sql_like_wildcard_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher_top: SQL LIKE pattern matcher
// Compiles a streamed pattern into a chain of literal, any and star cells
// and tracks the set of active pattern positions over a streamed text.
// A finish request reports the match, optionally inverted for NOT LIKE.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   in      | in_valid_i/in_ready_o| operation_i, char_value_i, negate_i
//   out     | out_valid_o/out_ready_i | matched_o, overflow_o
//
// Start, append and text requests update every position of the chain in
// parallel, so one such request is accepted per cycle while in_ready_o is high.
// A finish request passes a registered OR tree over the end-of-pattern hits
// and moves from the group registers into the output register once it is free.
// Reset leaves an empty pattern with only position zero active.
// A result waiting on out_ready_i holds one finish in the tree stage;
// in_ready_o drops only when both of them are full.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher_top import slwm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_value_i,
  input  logic       negate_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       overflow_o
);

  localparam int unsigned NumPos    = PATTERN_MAX + 1;
  localparam int unsigned NumGroups = (NumPos + GROUP_SIZE - 1) / GROUP_SIZE;

  op_e       op;
  logic      in_fire;
  logic      fin_fire;
  logic      out_load;
  cell_cmd_t cmd;
  logic      req_add;
  kind_e     req_kind;

  logic esc_q, esc_d;
  logic too_long_q, too_long_d;
  logic last_star_q, last_star_d;
  logic full;

  link_t                  link [NumPos+1];
  logic [NumPos-1:0]      tail;
  logic [NumPos-1:0]      hits;
  logic [NumGroups*GROUP_SIZE-1:0] hits_pad;
  logic [NumGroups-1:0]   grp_d, grp_q;

  logic fin_pend_q, fin_pend_d;
  logic fin_neg_q, fin_esc_q, fin_long_q;
  logic out_valid_q, out_valid_d;
  logic matched_q, overflow_q;
  logic plain;

  assign op       = op_e'(operation_i);
  assign in_fire  = in_valid_i & in_ready_o;
  assign fin_fire = in_fire & (op == OP_FINISH);

  // Decode the request into cell commands and compiler state
  always_comb begin
    cmd         = '0;
    cmd.ch      = char_value_i;
    req_add     = 1'b0;
    req_kind    = KIND_LITERAL;
    esc_d       = esc_q;
    too_long_d  = too_long_q;
    last_star_d = last_star_q;
    if (in_fire) begin
      case (op)
        OP_START: begin
          cmd.clear   = 1'b1;
          esc_d       = 1'b0;
          too_long_d  = 1'b0;
          last_star_d = 1'b0;
        end
        OP_APPEND: begin
          if (!too_long_q) begin
            if (esc_q) begin
              esc_d    = 1'b0;
              req_add  = 1'b1;
              req_kind = KIND_LITERAL;
            end else if (char_value_i == CH_BACKSLASH) begin
              esc_d = 1'b1;
            end else if (char_value_i == CH_PERCENT) begin
              req_add  = ~last_star_q;
              req_kind = KIND_STAR;
            end else if (char_value_i == CH_UNDERSCORE) begin
              req_add  = 1'b1;
              req_kind = KIND_ANY;
            end else begin
              req_add  = 1'b1;
              req_kind = KIND_LITERAL;
            end
          end
        end
        OP_TEXT: begin
          cmd.text = 1'b1;
        end
        OP_FINISH: begin
        end
        default: begin
        end
      endcase
    end
    cmd.kind = req_kind;
    if (req_add) begin
      if (full) begin
        too_long_d = 1'b1;
      end else begin
        cmd.add     = 1'b1;
        last_star_d = (req_kind == KIND_STAR);
      end
    end
  end

  // Hold compiler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= 1'b0;
      too_long_q  <= 1'b0;
      last_star_q <= 1'b0;
    end else begin
      esc_q       <= esc_d;
      too_long_q  <= too_long_d;
      last_star_q <= last_star_d;
    end
  end

  // Build the chain: position zero sees an always valid left edge
  assign link[0] = '{valid: 1'b1, star_act: 1'b0, adv: 1'b0};
  assign full    = link[PATTERN_MAX].valid;

  for (genvar i = 0; i < NumPos; i++) begin : g_cell
    slwm_cell #(
      .ActInit(i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (link[i]),
      .right_o(link[i+1]),
      .tail_o (tail[i]),
      .hit_o  (hits[i])
    );
  end

  // Reduce hits in groups, registered on finish
  always_comb begin
    hits_pad             = '0;
    hits_pad[NumPos-1:0] = hits;
  end

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    assign grp_d[g] = |hits_pad[g*GROUP_SIZE +: GROUP_SIZE];
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      grp_q      <= grp_d;
      fin_neg_q  <= negate_i;
      fin_esc_q  <= esc_q;
      fin_long_q <= too_long_q;
    end
  end

  // Advance the finish stage into the output register
  assign out_load   = fin_pend_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~fin_pend_q | out_load;

  always_comb begin
    fin_pend_d = fin_pend_q;
    if (fin_fire) begin
      fin_pend_d = 1'b1;
    end else if (out_load) begin
      fin_pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_pend_q  <= fin_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Resolve the result: pending escape kills the match, overflow forces zero
  assign plain = (|grp_q) & ~fin_esc_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      matched_q  <= ~fin_long_q & (plain ^ fin_neg_q);
      overflow_q <= fin_long_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

  // Checks
  a_tail_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tail))
    else $error("pattern tail pointer is not one-hot");

  a_last_pos_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link[NumPos].valid)
    else $error("position past the pattern store holds an entry");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (too_long_q && !(in_fire && (op == OP_START))) |=> too_long_q)
    else $error("overflow flag cleared without a start request");

  a_overflow_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> !matched_o)
    else $error("match reported on an overflowed pattern");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_pend_q && !out_load) |=> (fin_pend_q && $stable(grp_q)))
    else $error("finish stage lost while output stalled");

endmodule
